>>> src/gdfs_pkg.sv
package gdfs_pkg;

  localparam int SIDE_W       = 3;
  localparam int SIDE         = 1 << SIDE_W;
  localparam int CELL_W       = 2 * SIDE_W;
  localparam int CELLS        = 1 << CELL_W;
  localparam int DEPTH_W      = CELL_W + 1;
  localparam int SIZE_W       = 4;
  localparam int CFG_IDX_W    = 1;
  localparam int MAX_ROWS_DEF = 8;
  localparam int MAX_COLS_DEF = 8;

  localparam logic [CELL_W-1:0] CELL_LAST = CELL_W'(CELLS - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_STEP,
    ST_POP_WAIT,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [SIDE_W-1:0] start_row;
    logic [SIDE_W-1:0] start_col;
  } in_item_t;

  typedef struct packed {
    logic [SIDE_W-1:0] cell_row;
    logic [SIDE_W-1:0] cell_col;
    logic              last_cell;
    logic              bad_start;
  } out_item_t;

  typedef struct packed {
    logic [SIDE_W-1:0] row;
    logic [SIDE_W-1:0] col;
    dir_t              dir;
  } entry_t;

  typedef struct packed {
    logic              ok;
    logic [SIDE_W-1:0] row;
    logic [SIDE_W-1:0] col;
  } nbr_t;

  typedef struct packed {
    logic               we;
    logic [CELL_W-1:0]  waddr;
    entry_t             wdata;
    logic               re;
    logic [CELL_W-1:0]  raddr;
  } stk_ctl_t;

endpackage

>>> src/grid_dfs_visit_order.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  start_row, start_col
// out      output     out_valid/ out_stall cell_row, cell_col, last_cell, bad_start
// cfg      input      cfg_valid/ cfg_ready grid_rows (index 0), grid_cols (index 1)
//
// A search is accepted in ST_IDLE, then clears all 64 entries of the visited map one cell
// at a time, tries the four directions at each cell in turn and spends an extra ST_POP_WAIT
// state on each stack pop for the registered stack read. A start outside the grid still clears the map.
// The clearing pass, the neighbor unit and the registered stack read set the search time.
// The input stalls for the whole search, including the final result flush. Reset is
// synchronous and active low. A stalled output holds the walk only when a cell is emitted.
module grid_dfs_visit_order #(
  parameter int MAX_ROWS = gdfs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = gdfs_pkg::MAX_COLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  gdfs_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output gdfs_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gdfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gdfs_pkg::SIZE_W-1:0]      cfg_wdata
);

  localparam int ROW_LIM_I = (MAX_ROWS < gdfs_pkg::SIDE) ? MAX_ROWS : gdfs_pkg::SIDE;
  localparam int COL_LIM_I = (MAX_COLS < gdfs_pkg::SIDE) ? MAX_COLS : gdfs_pkg::SIDE;
  localparam logic [gdfs_pkg::SIZE_W-1:0] ROW_LIM = gdfs_pkg::SIZE_W'(ROW_LIM_I);
  localparam logic [gdfs_pkg::SIZE_W-1:0] COL_LIM = gdfs_pkg::SIZE_W'(COL_LIM_I);

  gdfs_pkg::state_t state_r, state_nxt;

  logic [gdfs_pkg::SIZE_W-1:0]  grid_rows_r;
  logic [gdfs_pkg::SIZE_W-1:0]  grid_cols_r;
  logic [gdfs_pkg::SIZE_W-1:0]  num_rows;
  logic [gdfs_pkg::SIZE_W-1:0]  num_cols;

  logic [gdfs_pkg::DEPTH_W-1:0] depth_r, depth_nxt;
  logic [gdfs_pkg::DEPTH_W-1:0] depth_m1;
  logic [gdfs_pkg::DEPTH_W-1:0] depth_m2;
  logic [gdfs_pkg::CELL_W-1:0]  clr_r, clr_nxt;
  gdfs_pkg::entry_t             top_r, top_nxt;
  logic [gdfs_pkg::SIDE_W-1:0]  pend_row_r, pend_row_nxt;
  logic [gdfs_pkg::SIDE_W-1:0]  pend_col_r, pend_col_nxt;
  logic                         pend_bad_r, pend_bad_nxt;
  logic                         out_valid_r, out_valid_nxt;
  gdfs_pkg::out_item_t          out_data_r, out_data_nxt;

  gdfs_pkg::nbr_t               nbr_r, nbr_nxt;
  gdfs_pkg::stk_ctl_t           stk_ctl;
  gdfs_pkg::entry_t             stk_rdata;

  logic                         seen_mem [gdfs_pkg::CELLS];
  logic                         seen_rd_r;
  logic                         seen_we;
  logic [gdfs_pkg::CELL_W-1:0]  seen_waddr;
  logic [gdfs_pkg::CELL_W-1:0]  seen_raddr;
  logic                         seen_wdata;

  logic                         can_emit;
  logic                         found;
  logic                         start_bad;

  assign num_rows   = (grid_rows_r > ROW_LIM) ? ROW_LIM : grid_rows_r;
  assign num_cols   = (grid_cols_r > COL_LIM) ? COL_LIM : grid_cols_r;
  assign start_bad  = ({1'b0, in_data.start_row} >= num_rows) ||
                      ({1'b0, in_data.start_col} >= num_cols);
  assign can_emit   = !out_valid_r || !out_stall;
  assign found      = nbr_r.ok && !seen_rd_r;
  assign depth_m1   = depth_r - 7'd1;
  assign depth_m2   = depth_r - 7'd2;
  assign seen_raddr = {nbr_nxt.row, nbr_nxt.col};

  assign in_stall  = (state_r != gdfs_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  gdfs_nbr u_nbr (
    .row      (top_nxt.row),
    .col      (top_nxt.col),
    .dir      (top_nxt.dir),
    .num_rows (num_rows),
    .num_cols (num_cols),
    .nbr      (nbr_nxt)
  );

  gdfs_stack u_stack (
    .clk   (clk),
    .ctl   (stk_ctl),
    .rdata (stk_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gdfs_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = gdfs_pkg::ST_CLEAR;
        end
      end
      gdfs_pkg::ST_CLEAR: begin
        if (clr_r == gdfs_pkg::CELL_LAST) begin
          state_nxt = pend_bad_r ? gdfs_pkg::ST_FLUSH : gdfs_pkg::ST_STEP;
        end
      end
      gdfs_pkg::ST_STEP: begin
        if ((top_r.dir == gdfs_pkg::DIR_RIGHT) && !found) begin
          state_nxt = (depth_r == 7'd1) ? gdfs_pkg::ST_FLUSH : gdfs_pkg::ST_POP_WAIT;
        end
      end
      gdfs_pkg::ST_POP_WAIT: begin
        state_nxt = gdfs_pkg::ST_STEP;
      end
      gdfs_pkg::ST_FLUSH: begin
        if (can_emit) begin
          state_nxt = gdfs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gdfs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    depth_nxt     = depth_r;
    clr_nxt       = clr_r;
    top_nxt       = top_r;
    pend_row_nxt  = pend_row_r;
    pend_col_nxt  = pend_col_r;
    pend_bad_nxt  = pend_bad_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    seen_we       = 1'b0;
    seen_waddr    = {nbr_r.row, nbr_r.col};
    seen_wdata    = 1'b1;
    stk_ctl       = '0;
    stk_ctl.wdata = top_r;
    stk_ctl.waddr = depth_m1[gdfs_pkg::CELL_W-1:0];
    stk_ctl.raddr = depth_m2[gdfs_pkg::CELL_W-1:0];
    case (state_r)
      gdfs_pkg::ST_IDLE: begin
        if (in_valid) begin
          clr_nxt      = '0;
          pend_row_nxt = in_data.start_row;
          pend_col_nxt = in_data.start_col;
          pend_bad_nxt = start_bad;
          top_nxt      = '{row: in_data.start_row, col: in_data.start_col,
                           dir: gdfs_pkg::DIR_UP};
          if (start_bad) begin
            depth_nxt = '0;
          end else begin
            depth_nxt = 7'd1;
          end
        end
      end
      gdfs_pkg::ST_CLEAR: begin
        seen_we    = 1'b1;
        seen_waddr = clr_r;
        seen_wdata = !pend_bad_r && (clr_r == {pend_row_r, pend_col_r});
        clr_nxt    = clr_r + 6'd1;
      end
      gdfs_pkg::ST_STEP: begin
        if (!(found && !can_emit)) begin
          if (found) begin
            seen_we       = 1'b1;
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{cell_row: pend_row_r, cell_col: pend_col_r,
                              last_cell: 1'b0, bad_start: 1'b0};
            pend_row_nxt  = nbr_r.row;
            pend_col_nxt  = nbr_r.col;
            top_nxt       = '{row: nbr_r.row, col: nbr_r.col, dir: gdfs_pkg::DIR_UP};
          end
          if (top_r.dir == gdfs_pkg::DIR_RIGHT) begin
            if (!found) begin
              depth_nxt  = depth_m1;
              stk_ctl.re = (depth_r != 7'd1);
            end
          end else begin
            if (found) begin
              stk_ctl.we        = 1'b1;
              stk_ctl.wdata.dir = gdfs_pkg::dir_t'(top_r.dir + 2'd1);
              depth_nxt         = depth_r + 7'd1;
            end else begin
              top_nxt.dir = gdfs_pkg::dir_t'(top_r.dir + 2'd1);
            end
          end
        end
      end
      gdfs_pkg::ST_POP_WAIT: begin
        top_nxt = stk_rdata;
      end
      gdfs_pkg::ST_FLUSH: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{cell_row: pend_row_r, cell_col: pend_col_r,
                            last_cell: 1'b1, bad_start: pend_bad_r};
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && out_stall;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (seen_we) begin
      seen_mem[seen_waddr] <= seen_wdata;
    end
    if (seen_we && (seen_waddr == seen_raddr)) begin
      seen_rd_r <= seen_wdata;
    end else begin
      seen_rd_r <= seen_mem[seen_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gdfs_pkg::ST_IDLE;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
      grid_rows_r <= gdfs_pkg::SIZE_RESET;
      grid_cols_r <= gdfs_pkg::SIZE_RESET;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gdfs_pkg::CFG_GRID_ROWS: grid_rows_r <= cfg_wdata;
          gdfs_pkg::CFG_GRID_COLS: grid_cols_r <= cfg_wdata;
          default: begin
            grid_rows_r <= grid_rows_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    clr_r      <= clr_nxt;
    nbr_r      <= nbr_nxt;
    top_r      <= top_nxt;
    pend_row_r <= pend_row_nxt;
    pend_col_r <= pend_col_nxt;
    pend_bad_r <= pend_bad_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

>>> src/gdfs_nbr.sv
module gdfs_nbr (
  input  logic [gdfs_pkg::SIDE_W-1:0] row,
  input  logic [gdfs_pkg::SIDE_W-1:0] col,
  input  gdfs_pkg::dir_t              dir,
  input  logic [gdfs_pkg::SIZE_W-1:0] num_rows,
  input  logic [gdfs_pkg::SIZE_W-1:0] num_cols,
  output gdfs_pkg::nbr_t              nbr
);

  logic [gdfs_pkg::SIZE_W-1:0] row_ext;
  logic [gdfs_pkg::SIZE_W-1:0] col_ext;

  assign row_ext = {1'b0, row};
  assign col_ext = {1'b0, col};

  always_comb begin
    nbr.row = row;
    nbr.col = col;
    nbr.ok  = 1'b0;
    case (dir)
      gdfs_pkg::DIR_UP: begin
        nbr.row = row - 3'd1;
        nbr.ok  = (row != '0);
      end
      gdfs_pkg::DIR_DOWN: begin
        nbr.row = row + 3'd1;
        nbr.ok  = ((row_ext + 4'd1) < num_rows);
      end
      gdfs_pkg::DIR_LEFT: begin
        nbr.col = col - 3'd1;
        nbr.ok  = (col != '0);
      end
      gdfs_pkg::DIR_RIGHT: begin
        nbr.col = col + 3'd1;
        nbr.ok  = ((col_ext + 4'd1) < num_cols);
      end
      default: begin
        nbr.ok = 1'b0;
      end
    endcase
  end

endmodule

>>> src/gdfs_stack.sv
module gdfs_stack (
  input  logic               clk,
  input  gdfs_pkg::stk_ctl_t ctl,
  output gdfs_pkg::entry_t   rdata
);

  gdfs_pkg::entry_t mem [gdfs_pkg::CELLS];
  gdfs_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
    if (ctl.re) begin
      rdata_r <= mem[ctl.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sim/grid_dfs_visit_order_tb.sv
module grid_dfs_visit_order_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gdfs_pkg::*;

  localparam int SETTLE_CYCLES = 400;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int REPORT_CAP    = 30;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_GRID_ROWS;
  logic [SIZE_W-1:0]    cfg_wdata = '0;

  logic [SIZE_W-1:0] rows_reg = SIZE_RESET;
  logic [SIZE_W-1:0] cols_reg = SIZE_RESET;
  out_item_t         expected_cells[$];

  int send_pct = 0;
  int recv_pct = 0;
  int err_count = 0;
  int searches_sent = 0;
  int cells_seen = 0;
  int settings_used = 0;
  int cycle_count = 0;

  grid_dfs_visit_order u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d cells outstanding.",
               cycle_count, expected_cells.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int used_side(logic [SIZE_W-1:0] size_v, int limit);
    int n;
    n = int'(size_v);
    if (n > limit) n = limit;
    if (n > SIDE) n = SIDE;
    return n;
  endfunction

  // Depth-first walk with an explicit stack; each cell is queued in preorder.
  function automatic void walk_grid(in_item_t it);
    int        nr, nc, sp, r, c;
    bit        seen[SIDE][SIDE];
    int        stk_r[CELLS];
    int        stk_c[CELLS];
    dir_t      stk_d[CELLS];
    dir_t      d;
    out_item_t prev;
    nr = used_side(rows_reg, MAX_ROWS_DEF);
    nc = used_side(cols_reg, MAX_COLS_DEF);
    if (int'(it.start_row) >= nr || int'(it.start_col) >= nc) begin
      expected_cells.push_back('{cell_row: it.start_row, cell_col: it.start_col,
                                 last_cell: 1'b1, bad_start: 1'b1});
      return;
    end
    foreach (seen[i, j]) seen[i][j] = 1'b0;
    r = int'(it.start_row);
    c = int'(it.start_col);
    seen[r][c] = 1'b1;
    stk_r[0] = r;
    stk_c[0] = c;
    stk_d[0] = DIR_UP;
    sp = 1;
    prev = '{cell_row: 3'(r), cell_col: 3'(c), last_cell: 1'b0, bad_start: 1'b0};
    while (sp > 0) begin
      r = stk_r[sp-1];
      c = stk_c[sp-1];
      d = stk_d[sp-1];
      case (d)
        DIR_UP:   r = r - 1;
        DIR_DOWN: r = r + 1;
        DIR_LEFT: c = c - 1;
        default:  c = c + 1;
      endcase
      if (d == DIR_RIGHT) sp--;
      else stk_d[sp-1] = dir_t'(d + 2'd1);
      if (r >= 0 && c >= 0 && r < nr && c < nc) begin
        if (!seen[r][c]) begin
          seen[r][c] = 1'b1;
          stk_r[sp] = r;
          stk_c[sp] = c;
          stk_d[sp] = DIR_UP;
          sp++;
          expected_cells.push_back(prev);
          prev = '{cell_row: 3'(r), cell_col: 3'(c), last_cell: 1'b0, bad_start: 1'b0};
        end
      end
    end
    prev.last_cell = 1'b1;
    expected_cells.push_back(prev);
  endfunction

  task automatic report_mismatch(string what, int exp_v, int got_v);
    err_count++;
    if (err_count <= REPORT_CAP)
      $display("Mismatch on %s: expected %0d, got %0d at %0t", what, exp_v, got_v, $realtime);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_stall <= ($urandom_range(99) < recv_pct);
    if (rst_n && out_valid && !out_stall) begin
      cells_seen++;
      if (expected_cells.size() == 0) begin
        report_mismatch("transaction with no search pending, cell_row", -1,
                        int'(out_data.cell_row));
      end else begin
        want = expected_cells.pop_front();
        if (out_data.cell_row !== want.cell_row)
          report_mismatch("cell_row", int'(want.cell_row), int'(out_data.cell_row));
        if (out_data.cell_col !== want.cell_col)
          report_mismatch("cell_col", int'(want.cell_col), int'(out_data.cell_col));
        if (out_data.last_cell !== want.last_cell)
          report_mismatch("last_cell", int'(want.last_cell), int'(out_data.last_cell));
        if (out_data.bad_start !== want.bad_start)
          report_mismatch("bad_start", int'(want.bad_start), int'(out_data.bad_start));
      end
    end
  end

  task automatic send_start(logic [SIDE_W-1:0] row, logic [SIDE_W-1:0] col);
    in_item_t it;
    it.start_row = row;
    it.start_col = col;
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    walk_grid(it);
    searches_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_GRID_ROWS) rows_reg = val;
    else cols_reg = val;
  endtask

  task automatic set_grid(logic [SIZE_W-1:0] rows, logic [SIZE_W-1:0] cols);
    drain();
    write_reg(CFG_GRID_ROWS, rows);
    write_reg(CFG_GRID_COLS, cols);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return SIZE_W'($urandom_range(4, 1));
    if (roll < 85) return SIZE_W'($urandom_range(8, 5));
    if (roll < 95) return SIZE_W'($urandom_range(15, 9));
    return '0;
  endfunction

  function automatic logic [SIDE_W-1:0] pick_coord(int n);
    if (n > 0 && $urandom_range(99) < 85) return SIDE_W'($urandom_range(n - 1, 0));
    return SIDE_W'($urandom_range(SIDE - 1, 0));
  endfunction

  task automatic test_reset_size();
    send_start(3'd0, 3'd0);
    send_start(3'd7, 3'd7);
    send_start(3'd0, 3'd7);
    send_start(3'd7, 3'd0);
    send_start(3'd3, 3'd4);
  endtask

  task automatic test_size_extremes();
    set_grid(4'd1, 4'd1);
    send_start(3'd0, 3'd0);
    send_start(3'd0, 3'd1);
    send_start(3'd1, 3'd0);
    set_grid(4'd0, 4'd5);
    send_start(3'd0, 3'd0);
    set_grid(4'd6, 4'd0);
    send_start(3'd2, 3'd0);
    set_grid(4'd15, 4'd15);
    send_start(3'd7, 3'd7);
    send_start(3'd0, 3'd0);
    set_grid(4'd1, 4'd8);
    send_start(3'd0, 3'd3);
    set_grid(4'd8, 4'd1);
    send_start(3'd5, 3'd0);
    set_grid(4'd3, 4'd2);
    send_start(3'd2, 3'd1);
    send_start(3'd7, 3'd7);
    send_start(3'd3, 3'd1);
  endtask

  task automatic test_random_walks();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_pct = 14;
          recv_pct = 87;
        end
        1: begin
          send_pct = 87;
          recv_pct = 14;
        end
        default: begin
          send_pct = 0;
          recv_pct = 0;
        end
      endcase
      for (int s = 0; s < 4; s++) begin
        set_grid(pick_size(), pick_size());
        repeat (18)
          send_start(pick_coord(used_side(rows_reg, MAX_ROWS_DEF)),
                     pick_coord(used_side(cols_reg, MAX_COLS_DEF)));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_pct = 14;
    recv_pct = 87;
    test_reset_size();
    test_size_extremes();
    test_random_walks();
    drain();
    $display("Ran %0d searches over %0d grid settings, including empty and oversized grids.",
             searches_sent, settings_used + 1);
    $display("Checked %0d visited cells under sender and receiver backpressure.", cells_seen);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
